@@ design/sprite_blit_scale_rotate_macros.svh @@
// Assertion macros shared by the sprite blitter RTL.
`ifndef SPRITE_BLIT_SCALE_ROTATE_MACROS_SVH
`define SPRITE_BLIT_SCALE_ROTATE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SBSR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SBSR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/sbsr_pkg.sv @@
// Shared types and constants of the sprite blitter.
package sbsr_pkg;

	localparam int COORD_W    = 8;
	localparam int ORG_W      = 12;
	localparam int PITCH_W    = 13;
	localparam int SIZE_W     = 9;
	localparam int RATIO_W    = 9;
	localparam int DIR_W      = 2;
	localparam int ADDR_W     = 25;
	localparam int PIX_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int SUM_W      = 13;
	localparam int PROD_W     = SUM_W + PITCH_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;
	localparam int DIV_STEPS   = COORD_W;

	localparam logic [SIZE_W-1:0] MAX_SPRITE = 9'd256;

	localparam logic [ORG_W-1:0]   ORIGIN_RST = 12'd0;
	localparam logic [PITCH_W-1:0] PITCH_RST  = 13'd1024;
	localparam logic [SIZE_W-1:0]  SIZE_RST   = 9'd64;
	localparam logic [RATIO_W-1:0] RATIO_RST  = 9'd1;

	localparam logic [DIR_W-1:0] DIR_EAST  = 2'd0;
	localparam logic [DIR_W-1:0] DIR_NORTH = 2'd1;
	localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd2;
	localparam logic [DIR_W-1:0] DIR_WEST  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd5;

	// Effective configuration, already clamped, as seen by front and back.
	typedef struct packed {
		logic [ORG_W-1:0]   origin_x;
		logic [ORG_W-1:0]   origin_y;
		logic [PITCH_W-1:0] pitch;
		logic [SIZE_W-1:0]  size;
		logic [RATIO_W-1:0] ratio;
		logic [DIR_W-1:0]   direction;
	} cfg_t;

	// Classified item travelling from front to back.
	typedef struct packed {
		logic               wr;
		logic [COORD_W-1:0] r;
		logic [COORD_W-1:0] c;
		logic [PIX_W-1:0]   pix;
	} item_t;

endpackage

@@ design/sbsr_front.sv @@
// Front end: accepts source pixels, tests opacity and bounds, applies orientation.
module sbsr_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sbsr_pkg::cfg_t                   cfg,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [sbsr_pkg::COORD_W-1:0]     src_row,
	input  logic [sbsr_pkg::COORD_W-1:0]     src_col,
	input  logic signed [sbsr_pkg::PIX_W-1:0] pixel,
	output logic                             push_valid,
	input  logic                             push_ready,
	output sbsr_pkg::item_t                  push_item
);

	logic                          v_s1;
	sbsr_pkg::item_t               item_s1;
	sbsr_pkg::item_t               cls;
	logic [sbsr_pkg::SIZE_W-1:0]   row_w;
	logic [sbsr_pkg::SIZE_W-1:0]   col_w;
	logic [sbsr_pkg::SIZE_W-1:0]   mir_row;
	logic [sbsr_pkg::SIZE_W-1:0]   mir_col;
	logic                          opaque;
	logic                          in_bounds;

	always_comb begin
		row_w     = {1'b0, src_row};
		col_w     = {1'b0, src_col};
		mir_row   = cfg.size - 9'd1 - row_w;
		mir_col   = cfg.size - 9'd1 - col_w;
		opaque    = ~pixel[sbsr_pkg::PIX_W-1] & (|pixel);
		in_bounds = (row_w < cfg.size) && (col_w < cfg.size);
		cls.wr    = opaque & in_bounds;
		cls.pix   = pixel;
		case (cfg.direction)
			sbsr_pkg::DIR_EAST: begin
				cls.r = src_row;
				cls.c = src_col;
			end
			sbsr_pkg::DIR_NORTH: begin
				cls.r = src_col;
				cls.c = src_row;
			end
			sbsr_pkg::DIR_SOUTH: begin
				cls.r = mir_col[sbsr_pkg::COORD_W-1:0];
				cls.c = mir_row[sbsr_pkg::COORD_W-1:0];
			end
			sbsr_pkg::DIR_WEST: begin
				cls.r = src_row;
				cls.c = mir_col[sbsr_pkg::COORD_W-1:0];
			end
			default: begin
				cls.r = src_row;
				cls.c = src_col;
			end
		endcase
	end

	assign in_ready   = ~v_s1 | push_ready;
	assign push_valid = v_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= cls;
		end
	end

endmodule

@@ design/sbsr_queue.sv @@
// Short queue between the classifying front end and the address back end.
module sbsr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  sbsr_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output sbsr_pkg::item_t pop_item
);

	sbsr_pkg::item_t                 mem_q [sbsr_pkg::QUEUE_DEPTH];
	logic [sbsr_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [sbsr_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [sbsr_pkg::QUEUE_AW:0]     count_q;
	logic                            push;
	logic                            pop;

	assign push_ready = count_q != (sbsr_pkg::QUEUE_AW+1)'(sbsr_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ design/sbsr_back.sv @@
// Back end: pipelined division by the scale ratio and framebuffer address computation.
module sbsr_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sbsr_pkg::cfg_t                    cfg,
	input  logic                              pop_valid,
	output logic                              pop_ready,
	input  sbsr_pkg::item_t                   pop_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              write_enable,
	output logic [sbsr_pkg::ADDR_W-1:0]       dest_address,
	output logic signed [sbsr_pkg::PIX_W-1:0] color
);

	// Restoring division of both coordinates: remainder plus a word that
	// shifts the dividend out at the top and the quotient in at the bottom.
	typedef struct packed {
		logic                          wr;
		logic [sbsr_pkg::PIX_W-1:0]    pix;
		logic [sbsr_pkg::RATIO_W-1:0]  rem_r;
		logic [sbsr_pkg::COORD_W-1:0]  nq_r;
		logic [sbsr_pkg::RATIO_W-1:0]  rem_c;
		logic [sbsr_pkg::COORD_W-1:0]  nq_c;
	} div_t;

	function automatic logic [sbsr_pkg::RATIO_W+sbsr_pkg::COORD_W-1:0] div_bit(
		input logic [sbsr_pkg::RATIO_W-1:0] rem,
		input logic [sbsr_pkg::COORD_W-1:0] nq,
		input logic [sbsr_pkg::RATIO_W-1:0] d
	);
		logic [sbsr_pkg::RATIO_W:0] trial;
		logic [sbsr_pkg::RATIO_W:0] diff;
		trial = {rem, nq[sbsr_pkg::COORD_W-1]};
		diff  = trial - {1'b0, d};
		if (trial >= {1'b0, d}) begin
			div_bit = {diff[sbsr_pkg::RATIO_W-1:0], nq[sbsr_pkg::COORD_W-2:0], 1'b1};
		end else begin
			div_bit = {trial[sbsr_pkg::RATIO_W-1:0], nq[sbsr_pkg::COORD_W-2:0], 1'b0};
		end
	endfunction

	function automatic div_t div_step(input div_t d, input logic [sbsr_pkg::RATIO_W-1:0] ratio);
		div_t res;
		res = d;
		{res.rem_r, res.nq_r} = div_bit(d.rem_r, d.nq_r, ratio);
		{res.rem_c, res.nq_c} = div_bit(d.rem_c, d.nq_c, ratio);
		div_step = res;
	endfunction

	div_t                                div_s   [sbsr_pkg::DIV_STEPS];
	logic [sbsr_pkg::DIV_STEPS-1:0]      div_v_s;
	div_t                                div_in;
	logic                                v_s9;
	logic                                wr_s9;
	logic [sbsr_pkg::PIX_W-1:0]          pix_s9;
	logic [sbsr_pkg::SUM_W-1:0]          row_sum_s9;
	logic [sbsr_pkg::SUM_W-1:0]          col_sum_s9;
	logic                                v_s10;
	logic                                wr_s10;
	logic [sbsr_pkg::PIX_W-1:0]          pix_s10;
	logic [sbsr_pkg::PROD_W-1:0]         prod_s10;
	logic [sbsr_pkg::SUM_W-1:0]          col_sum_s10;
	logic                                adv;
	div_t                                last;

	assign adv       = ~out_valid | out_ready;
	assign pop_ready = adv;
	assign last      = div_s[sbsr_pkg::DIV_STEPS-1];

	always_comb begin
		div_in.wr    = pop_item.wr;
		div_in.pix   = pop_item.pix;
		div_in.rem_r = '0;
		div_in.nq_r  = pop_item.r;
		div_in.rem_c = '0;
		div_in.nq_c  = pop_item.c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s   <= '0;
			v_s9      <= 1'b0;
			v_s10     <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			div_v_s   <= {div_v_s[sbsr_pkg::DIV_STEPS-2:0], pop_valid};
			v_s9      <= div_v_s[sbsr_pkg::DIV_STEPS-1];
			v_s10     <= v_s9;
			out_valid <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= div_step(div_in, cfg.ratio);
			for (int k = 1; k < sbsr_pkg::DIV_STEPS; k++) begin
				div_s[k] <= div_step(div_s[k-1], cfg.ratio);
			end
			wr_s9       <= last.wr;
			pix_s9      <= last.pix;
			row_sum_s9  <= {1'b0, cfg.origin_y} + {5'b0, last.nq_r};
			col_sum_s9  <= {1'b0, cfg.origin_x} + {5'b0, last.nq_c};
			wr_s10      <= wr_s9;
			pix_s10     <= pix_s9;
			prod_s10    <= row_sum_s9 * cfg.pitch;
			col_sum_s10 <= col_sum_s9;
			write_enable <= wr_s10;
			if (wr_s10) begin
				dest_address <= prod_s10[sbsr_pkg::ADDR_W-1:0] + {12'b0, col_sum_s10};
				color        <= pix_s10;
			end else begin
				dest_address <= '0;
				color        <= '0;
			end
		end
	end

endmodule

@@ design/sprite_blit_scale_rotate.sv @@
// Top level of the sprite blitter: configuration registers, front end, queue and back end.

// The block places one pixel of a square colour-keyed sprite per transfer. Each input
// transfer carries a source row, column and signed 32-bit pixel; each output transfer
// gives write_enable, the framebuffer word address and the colour. Pixels that are not
// above zero, or that lie outside the sprite, come out with write_enable low and a zero
// address and colour. The orientation register swaps or mirrors the coordinates, both
// are divided by the downscale ratio, and the address is
// (origin_y + r/ratio) * dest_pitch + origin_x + c/ratio, wrapped to 25 bits.
// One item is taken per clock cycle when the output side keeps taking results; each input
// transfer passes through the front-end register, the queue and the eight-stage
// bit-per-stage divider in the back end, followed by an add, a multiply and a final add.
// A four-entry queue separates the classifying front end from the back end, so a stall
// on the output lets the input keep taking items until the queue fills. Configuration
// must be written only while no items are in flight; writes take effect at once.
`include "sprite_blit_scale_rotate_macros.svh"

module sprite_blit_scale_rotate (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [sbsr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sbsr_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [sbsr_pkg::COORD_W-1:0]          src_row,
	input  logic [sbsr_pkg::COORD_W-1:0]          src_col,
	input  logic signed [sbsr_pkg::PIX_W-1:0]     pixel,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  write_enable,
	output logic [sbsr_pkg::ADDR_W-1:0]           dest_address,
	output logic signed [sbsr_pkg::PIX_W-1:0]     color
);

	logic [sbsr_pkg::ORG_W-1:0]    origin_x_q;
	logic [sbsr_pkg::ORG_W-1:0]    origin_y_q;
	logic [sbsr_pkg::PITCH_W-1:0]  dest_pitch_q;
	logic [sbsr_pkg::SIZE_W-1:0]   sprite_size_q;
	logic [sbsr_pkg::RATIO_W-1:0]  scale_ratio_q;
	logic [sbsr_pkg::DIR_W-1:0]    direction_q;
	sbsr_pkg::cfg_t                cfg;

	logic                          fq_valid;
	logic                          fq_ready;
	sbsr_pkg::item_t               fq_item;
	logic                          qb_valid;
	logic                          qb_ready;
	sbsr_pkg::item_t               qb_item;

	// Registers are taken as written; the clamping of the sprite size to the largest
	// supported sprite and of a zero ratio to one is applied here, once, for both ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= sbsr_pkg::ORIGIN_RST;
			origin_y_q    <= sbsr_pkg::ORIGIN_RST;
			dest_pitch_q  <= sbsr_pkg::PITCH_RST;
			sprite_size_q <= sbsr_pkg::SIZE_RST;
			scale_ratio_q <= sbsr_pkg::RATIO_RST;
			direction_q   <= sbsr_pkg::DIR_EAST;
		end else if (cfg_we) begin
			case (cfg_index)
				sbsr_pkg::REG_ORIGIN_X:  origin_x_q    <= cfg_wdata[sbsr_pkg::ORG_W-1:0];
				sbsr_pkg::REG_ORIGIN_Y:  origin_y_q    <= cfg_wdata[sbsr_pkg::ORG_W-1:0];
				sbsr_pkg::REG_PITCH:     dest_pitch_q  <= cfg_wdata[sbsr_pkg::PITCH_W-1:0];
				sbsr_pkg::REG_SIZE:      sprite_size_q <= cfg_wdata[sbsr_pkg::SIZE_W-1:0];
				sbsr_pkg::REG_RATIO:     scale_ratio_q <= cfg_wdata[sbsr_pkg::RATIO_W-1:0];
				sbsr_pkg::REG_DIRECTION: direction_q   <= cfg_wdata[sbsr_pkg::DIR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.origin_x  = origin_x_q;
		cfg.origin_y  = origin_y_q;
		cfg.pitch     = dest_pitch_q;
		cfg.size      = (sprite_size_q > sbsr_pkg::MAX_SPRITE) ? sbsr_pkg::MAX_SPRITE
			: sprite_size_q;
		cfg.ratio     = (scale_ratio_q == '0) ? sbsr_pkg::RATIO_W'(1) : scale_ratio_q;
		cfg.direction = direction_q;
	end

	sbsr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.src_row    (src_row),
		.src_col    (src_col),
		.pixel      (pixel),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item)
	);

	sbsr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_item   (qb_item)
	);

	sbsr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.pop_valid    (qb_valid),
		.pop_ready    (qb_ready),
		.pop_item     (qb_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_enable (write_enable),
		.dest_address (dest_address),
		.color        (color)
	);

	// A skipped pixel must carry a zero address and colour.
	`SBSR_ASSERT_IMP(a_skip_zero, out_valid && !write_enable, dest_address == '0 && color == '0, "skipped pixel with non-zero payload")
	// Only opaque pixels, which are strictly positive, may be written.
	`SBSR_ASSERT_IMP(a_write_opaque, out_valid && write_enable, $signed(color) > 0, "write of a transparent pixel")
	// A full queue is never also empty.
	`SBSR_ASSERT_IMP(a_queue_full, !fq_ready, qb_valid, "queue reports full and empty together")
	// An accepted item is offered to the queue on the following cycle.
	`SBSR_ASSERT_NXT(a_front_hold, in_valid && in_ready, fq_valid, "accepted item lost in the front end")

endmodule
